FILE: src/smx_pkg.sv
package smx_pkg;

    localparam int unsigned WORD_W = 32;

    typedef enum logic [3:0] {
        OP_ADD   = 4'd0,
        OP_SUB   = 4'd1,
        OP_MUL   = 4'd2,
        OP_DIV   = 4'd3,
        OP_IN    = 4'd4,
        OP_PUSH  = 4'd5,
        OP_SQRT  = 4'd6,
        OP_OUT   = 4'd7,
        OP_HLT   = 4'd8,
        OP_POPR  = 4'd9,
        OP_PUSHR = 4'd10,
        OP_JB    = 4'd11,
        OP_CALL  = 4'd12,
        OP_RET   = 4'd13
    } t_op;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_UNDERFLOW  = 3'd1;
    localparam logic [2:0] ST_OVERFLOW   = 3'd2;
    localparam logic [2:0] ST_DIV_ZERO   = 3'd3;
    localparam logic [2:0] ST_NEG_SQRT   = 3'd4;
    localparam logic [2:0] ST_BAD_OP     = 3'd5;
    localparam logic [2:0] ST_RET_EMPTY  = 3'd6;

    typedef struct packed {
        logic start;
        logic sqrt;
    } t_iter_req;

    typedef struct packed {
        logic                done;
        logic [WORD_W-1:0]   result;
    } t_iter_rsp;

endpackage

FILE: src/smx_dstack.sv
module smx_dstack import smx_pkg::*; #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = 4
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [WORD_W-1:0] i_wdata,
    input  logic [AW-1:0]     i_raddr_a,
    input  logic [AW-1:0]     i_raddr_b,
    output logic [WORD_W-1:0] o_rdata_a,
    output logic [WORD_W-1:0] o_rdata_b
);

    logic [WORD_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

FILE: src/smx_iter.sv
module smx_iter import smx_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_iter_req         i_req,
    input  logic [WORD_W-1:0] i_left,
    input  logic [WORD_W-1:0] i_right,
    output t_iter_rsp         o_rsp
);

    logic              r_busy;
    logic              r_sqrt;
    logic [5:0]        r_cnt;
    logic              r_neg;
    logic [WORD_W:0]   r_rem;
    logic [WORD_W-1:0] r_quo;
    logic [WORD_W-1:0] r_div;
    logic [15:0]       r_root;
    logic              r_done;

    logic [WORD_W-1:0] l_mag;
    logic [WORD_W-1:0] r_mag;
    logic [WORD_W:0]   d_trial;
    logic [17:0]       s_rem;
    logic [17:0]       s_trial;

    assign l_mag   = i_left[WORD_W-1]  ? (~i_left + 1'b1)  : i_left;
    assign r_mag   = i_right[WORD_W-1] ? (~i_right + 1'b1) : i_right;
    assign d_trial = {r_rem[WORD_W-1:0], r_quo[WORD_W-1]};
    // Sqrt step: bring down two bits and try (root << 2) | 1.
    assign s_rem   = {r_rem[15:0], r_quo[WORD_W-1 -: 2]};
    assign s_trial = {r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.sqrt ? 6'd16 : 6'd32;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_sqrt <= i_req.sqrt;
            r_rem  <= '0;
            r_root <= '0;
            r_quo  <= i_req.sqrt ? i_right : l_mag;
            r_div  <= r_mag;
            r_neg  <= i_left[WORD_W-1] ^ i_right[WORD_W-1];
        end else if (r_busy) begin
            if (r_sqrt) begin
                r_quo <= {r_quo[WORD_W-3:0], 2'b00};
                if (s_rem >= s_trial) begin
                    r_rem  <= {{(WORD_W-17){1'b0}}, s_rem - s_trial};
                    r_root <= {r_root[14:0], 1'b1};
                end else begin
                    r_rem  <= {{(WORD_W-17){1'b0}}, s_rem};
                    r_root <= {r_root[14:0], 1'b0};
                end
            end else begin
                if (d_trial >= {1'b0, r_div}) begin
                    r_rem <= d_trial - {1'b0, r_div};
                    r_quo <= {r_quo[WORD_W-2:0], 1'b1};
                end else begin
                    r_rem <= d_trial;
                    r_quo <= {r_quo[WORD_W-2:0], 1'b0};
                end
            end
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_sqrt ? {16'd0, r_root} : (r_neg ? (~r_quo + 1'b1) : r_quo);

endmodule

FILE: src/stack_machine_execute_core.sv
// An accepted transaction goes through EXEC, then WAIT for division and square root
// (which use the shared bit-serial unit), then WB, where its result is loaded.
// One instruction at a time: o_stall is high until the load, which i_stall can delay.
// Stack entries are read through registered read ports; a write lands before the next read.
// Reset (synchronous, active low) clears counts, registers, pointer, halt and length.
module stack_machine_execute_core import smx_pkg::*; #(
    parameter int unsigned DATA_STACK_DEPTH   = 16,
    parameter int unsigned RETURN_STACK_DEPTH = 16,
    parameter int unsigned IP_WIDTH           = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [3:0]  i_mode,
    input  logic signed [31:0] i_immediate,
    input  logic [1:0]  i_reg_select,
    input  logic signed [31:0] i_in_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_next_ip,
    output logic signed [31:0] o_out_value,
    output logic        o_out_valid,
    output logic        o_halted,
    output logic [2:0]  o_status
);

    localparam int unsigned DCW = $clog2(DATA_STACK_DEPTH + 1);
    localparam int unsigned DAW = $clog2(DATA_STACK_DEPTH);
    localparam int unsigned RCW = $clog2(RETURN_STACK_DEPTH + 1);
    localparam int unsigned RAW = (RETURN_STACK_DEPTH > 1) ? $clog2(RETURN_STACK_DEPTH) : 1;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_WAIT = 4'b0100,
        S_WB   = 4'b1000
    } t_state;

    t_state r_state, n_state;

    logic [15:0]          r_plen;
    logic [IP_WIDTH-1:0]  r_ip;
    logic                 r_halt;
    logic [DCW-1:0]       r_dcnt;
    logic [RCW-1:0]       r_rcnt;
    logic [WORD_W-1:0]    r_greg [4];

    logic [3:0]           r_mode;
    logic [WORD_W-1:0]    r_imm;
    logic [1:0]           r_rsel;
    logic [WORD_W-1:0]    r_inval;

    logic [IP_WIDTH-1:0]  r_rmem [RETURN_STACK_DEPTH];
    logic [IP_WIDTH-1:0]  r_rtop;

    logic [WORD_W-1:0]    d_top, d_sec;
    logic [DCW-1:0]       dcnt_m1, dcnt_m2;
    logic [RCW-1:0]       rcnt_m1;

    // Pending write-back, computed in EXEC.
    logic [IP_WIDTH-1:0]  e_ip,     r_p_ip;
    logic                 e_halt,   r_p_halt;
    logic [2:0]           e_status, r_p_status;
    logic [DCW-1:0]       e_dcnt,   r_p_dcnt;
    logic [RCW-1:0]       e_rcnt,   r_p_rcnt;
    logic                 e_dwe,    r_p_dwe;
    logic [DAW-1:0]       e_dwaddr, r_p_dwaddr;
    logic [WORD_W-1:0]    e_dwdata, r_p_dwdata;
    logic                 e_rwe,    r_p_rwe;
    logic                 e_gwe,    r_p_gwe;
    logic [WORD_W-1:0]    e_oval,   r_p_oval;
    logic                 e_ovalid, r_p_ovalid;
    logic                 e_iter,   r_p_iter;
    logic                 e_sqrt;

    logic                 in_acc, out_load, ip_end;
    logic [WORD_W-1:0]    wb_data;
    logic [WORD_W-1:0]    prod;
    t_iter_req            iter_req;
    t_iter_rsp            iter_rsp;

    assign in_acc  = i_valid && !o_stall;
    assign o_stall = (r_state != S_IDLE);
    assign dcnt_m1 = r_dcnt - DCW'(1);
    assign dcnt_m2 = r_dcnt - DCW'(2);
    assign rcnt_m1 = r_rcnt - RCW'(1);
    assign prod    = d_sec * d_top;

    smx_dstack #(.DEPTH(DATA_STACK_DEPTH), .AW(DAW)) u_dstack (
        .i_clk     (i_clk),
        .i_we      (out_load && r_p_dwe),
        .i_waddr   (r_p_dwaddr),
        .i_wdata   (wb_data),
        .i_raddr_a (dcnt_m1[DAW-1:0]),
        .i_raddr_b (dcnt_m2[DAW-1:0]),
        .o_rdata_a (d_top),
        .o_rdata_b (d_sec)
    );

    assign iter_req.start = (r_state == S_EXEC) && e_iter;
    assign iter_req.sqrt  = e_sqrt;

    smx_iter u_iter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (iter_req),
        .i_left  (d_sec),
        .i_right (d_top),
        .o_rsp   (iter_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (out_load && r_p_rwe) begin
            r_rmem[r_rcnt[RAW-1:0]] <= r_ip + IP_WIDTH'(2);
        end
        r_rtop <= r_rmem[rcnt_m1[RAW-1:0]];
    end

    always_comb begin
        e_ip     = r_ip;
        e_halt   = r_halt;
        e_status = ST_OK;
        e_dcnt   = r_dcnt;
        e_rcnt   = r_rcnt;
        e_dwe    = 1'b0;
        e_dwaddr = dcnt_m1[DAW-1:0];
        e_dwdata = '0;
        e_rwe    = 1'b0;
        e_gwe    = 1'b0;
        e_oval   = '0;
        e_ovalid = 1'b0;
        e_iter   = 1'b0;
        e_sqrt   = 1'b0;
        if (r_halt || (32'(r_ip) >= 32'(r_plen))) begin
            e_halt = 1'b1;
        end else begin
            case (r_mode)
                OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                    e_ip = r_ip + IP_WIDTH'(1);
                    if (r_dcnt < DCW'(2)) begin
                        e_status = ST_UNDERFLOW;
                    end else if (r_mode == OP_DIV && d_top == '0) begin
                        e_status = ST_DIV_ZERO;
                    end else begin
                        e_dcnt   = dcnt_m1;
                        e_dwe    = 1'b1;
                        e_dwaddr = dcnt_m2[DAW-1:0];
                        e_iter   = (r_mode == OP_DIV);
                        if (r_mode == OP_ADD) begin
                            e_dwdata = d_sec + d_top;
                        end else if (r_mode == OP_SUB) begin
                            e_dwdata = d_sec - d_top;
                        end else begin
                            e_dwdata = prod;
                        end
                    end
                end
                OP_IN, OP_PUSH, OP_PUSHR: begin
                    e_ip = r_ip + IP_WIDTH'(2);
                    if (r_dcnt >= DCW'(DATA_STACK_DEPTH)) begin
                        e_status = ST_OVERFLOW;
                    end else begin
                        e_dcnt   = r_dcnt + DCW'(1);
                        e_dwe    = 1'b1;
                        e_dwaddr = r_dcnt[DAW-1:0];
                        if (r_mode == OP_IN) begin
                            e_dwdata = r_inval;
                        end else if (r_mode == OP_PUSH) begin
                            e_dwdata = r_imm;
                        end else begin
                            e_dwdata = r_greg[r_rsel];
                        end
                    end
                end
                OP_SQRT: begin
                    e_ip = r_ip + IP_WIDTH'(1);
                    if (r_dcnt == '0) begin
                        e_status = ST_UNDERFLOW;
                    end else if (d_top[WORD_W-1]) begin
                        e_dcnt   = dcnt_m1;
                        e_status = ST_NEG_SQRT;
                    end else begin
                        e_dwe  = 1'b1;
                        e_iter = 1'b1;
                        e_sqrt = 1'b1;
                    end
                end
                OP_OUT: begin
                    e_ip = r_ip + IP_WIDTH'(1);
                    if (r_dcnt == '0) begin
                        e_status = ST_UNDERFLOW;
                    end else begin
                        e_dcnt   = dcnt_m1;
                        e_oval   = d_top;
                        e_ovalid = 1'b1;
                    end
                end
                OP_HLT: begin
                    e_halt = 1'b1;
                end
                OP_POPR: begin
                    e_ip = r_ip + IP_WIDTH'(2);
                    if (r_dcnt == '0) begin
                        e_status = ST_UNDERFLOW;
                    end else begin
                        e_dcnt = dcnt_m1;
                        e_gwe  = 1'b1;
                    end
                end
                OP_JB: begin
                    if (r_dcnt < DCW'(2)) begin
                        e_status = ST_UNDERFLOW;
                        e_ip     = r_ip + IP_WIDTH'(2);
                    end else if ($signed(d_sec) < $signed(d_top)) begin
                        e_ip = r_imm[IP_WIDTH-1:0];
                    end else begin
                        e_ip = r_ip + IP_WIDTH'(2);
                    end
                end
                OP_CALL: begin
                    if (r_rcnt >= RCW'(RETURN_STACK_DEPTH)) begin
                        e_status = ST_OVERFLOW;
                        e_ip     = r_ip + IP_WIDTH'(2);
                    end else begin
                        e_rwe  = 1'b1;
                        e_rcnt = r_rcnt + RCW'(1);
                        e_ip   = r_imm[IP_WIDTH-1:0];
                    end
                end
                OP_RET: begin
                    if (r_rcnt == '0) begin
                        e_status = ST_RET_EMPTY;
                        e_ip     = r_ip + IP_WIDTH'(1);
                    end else begin
                        e_rcnt = rcnt_m1;
                        e_ip   = r_rtop;
                    end
                end
                default: begin
                    e_status = ST_BAD_OP;
                    e_halt   = 1'b1;
                end
            endcase
        end
        if (32'(e_ip) >= 32'(r_plen)) begin
            e_halt = 1'b1;
        end
    end

    assign ip_end   = (r_state == S_WB);
    assign out_load = ip_end && (!o_valid || !i_stall);
    assign wb_data  = r_p_iter ? iter_rsp.result : r_p_dwdata;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (in_acc) n_state = S_EXEC;
            S_EXEC:  n_state = e_iter ? S_WAIT : S_WB;
            S_WAIT:  if (iter_rsp.done) n_state = S_WB;
            S_WB:    if (out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_plen  <= '0;
            r_ip    <= '0;
            r_halt  <= 1'b0;
            r_dcnt  <= '0;
            r_rcnt  <= '0;
            o_valid <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                r_greg[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_plen <= i_cfg_data;
            end
            if (out_load) begin
                r_ip    <= r_p_ip;
                r_halt  <= r_p_halt;
                r_dcnt  <= r_p_dcnt;
                r_rcnt  <= r_p_rcnt;
                o_valid <= 1'b1;
                if (r_p_gwe) begin
                    r_greg[r_rsel] <= d_top;
                end
            end else if (!i_stall) begin
                o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mode  <= i_mode;
            r_imm   <= i_immediate;
            r_rsel  <= i_reg_select;
            r_inval <= i_in_value;
        end
        if (r_state == S_EXEC) begin
            r_p_ip     <= e_ip;
            r_p_halt   <= e_halt;
            r_p_status <= e_status;
            r_p_dcnt   <= e_dcnt;
            r_p_rcnt   <= e_rcnt;
            r_p_dwe    <= e_dwe;
            r_p_dwaddr <= e_dwaddr;
            r_p_dwdata <= e_dwdata;
            r_p_rwe    <= e_rwe;
            r_p_gwe    <= e_gwe;
            r_p_oval   <= e_oval;
            r_p_ovalid <= e_ovalid;
            r_p_iter   <= e_iter;
        end
        if (out_load) begin
            o_next_ip   <= 16'(32'(r_p_ip));
            o_out_value <= r_p_oval;
            o_out_valid <= r_p_ovalid;
            o_halted    <= r_p_halt;
            o_status    <= r_p_status;
        end
    end

    a_dcnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_dcnt) <= DATA_STACK_DEPTH) else $error("data stack count out of range");

    a_rcnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_rcnt) <= RETURN_STACK_DEPTH) else $error("return stack count out of range");

    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |=> r_halt) else $error("halt flag cleared without reset");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_EXEC)) else $error("accepted transaction not executed");

    a_iter_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        iter_rsp.done |-> (r_state == S_WAIT)) else $error("iterative result outside wait");

endmodule
